@@ sv/mpt_pkg.sv @@
package mpt_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int ACC_W          = 32;
   localparam int SENS_W         = 10;
   localparam int LIMIT_W        = 12;
   localparam int VALUE_W        = 16;
   localparam int KIND_W         = 4;
   localparam int WHEEL_W        = 16;
   localparam int BTN_W          = 8;
   localparam int BTN_IDX_W      = 3;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 12;
   localparam int REQ_USER_W     = 1 + KIND_W;
   localparam int PRESS_BIT      = 7;

   localparam logic [LIMIT_W-1:0] X_LIMIT_RST = LIMIT_W'(319);
   localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = LIMIT_W'(199);
   localparam logic [SENS_W-1:0]  X_SENS_RST  = SENS_W'(135);
   localparam logic [SENS_W-1:0]  Y_SENS_RST  = SENS_W'(135);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LIMIT = 2'd0,
      CSR_Y_LIMIT = 2'd1,
      CSR_X_SENS  = 2'd2,
      CSR_Y_SENS  = 2'd3
   } csr_index_type;

   localparam logic [KIND_W-1:0] KIND_X_DELTA = 4'd0;
   localparam logic [KIND_W-1:0] KIND_Y_DELTA = 4'd1;
   localparam logic [KIND_W-1:0] KIND_WHEEL   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_BTN0    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_BTN7    = 4'd10;

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_BATCH = 1'b1;

   typedef struct packed {
      logic apply_event;
      logic start_x;
      logic next_y;
      logic finish_y;
   } mpt_cmd_type;

   typedef struct packed {
      logic div_done;
   } mpt_stat_type;

endpackage

@@ sv/mpt_div.sv @@
module mpt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mpt_pkg::ACC_W-1:0]  dividend,
   input  logic [mpt_pkg::SENS_W-1:0] divisor,
   output logic                        done,
   output logic [mpt_pkg::ACC_W-1:0]  quotient,
   output logic [mpt_pkg::SENS_W-1:0] remainder
);
   import mpt_pkg::*;

   localparam int CNT_W = $clog2(ACC_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ACC_W-1:0]   quo_ff, quo_in;
   logic [SENS_W-1:0]  rem_ff, rem_in;
   logic [SENS_W-1:0]  div_ff, div_in;
   logic [SENS_W:0]    shifted;
   logic [SENS_W+1:0]  diff;
   logic               fits;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      shifted  = {rem_ff, quo_ff[ACC_W-1]};
      diff     = {1'b0, shifted} - {2'b00, div_ff};
      fits     = ~diff[SENS_W+1];
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[ACC_W-2:0], fits};
         rem_in   = fits ? diff[SENS_W-1:0] : shifted[SENS_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/mpt_dp.sv @@
module mpt_dp #(
   parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mpt_pkg::mpt_cmd_type                  cmd,
   output mpt_pkg::mpt_stat_type                 stat,
   input  logic [mpt_pkg::KIND_W-1:0]            event_kind,
   input  logic signed [mpt_pkg::VALUE_W-1:0]    event_value,
   input  logic                                  csr_write,
   input  logic [mpt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mpt_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic [COORD_BITS-1:0]                 pointer_x,
   output logic [COORD_BITS-1:0]                 pointer_y,
   output logic signed [mpt_pkg::WHEEL_W-1:0]    wheel_count,
   output logic [mpt_pkg::BTN_W-1:0]             button_bits
);
   import mpt_pkg::*;

   localparam int LW  = (LIMIT_W > COORD_BITS) ? LIMIT_W : COORD_BITS;
   localparam int PSW = ACC_W + 2;

   logic [LIMIT_W-1:0]       x_limit_ff, y_limit_ff;
   logic [SENS_W-1:0]        x_sens_ff, y_sens_ff;
   logic signed [ACC_W-1:0]  x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic [COORD_BITS-1:0]    ptr_x_ff, ptr_x_in, ptr_y_ff, ptr_y_in;
   logic [WHEEL_W-1:0]       wheel_ff, wheel_in;
   logic [BTN_W-1:0]         btn_ff, btn_in;
   logic                     neg_ff, neg_in;

   logic signed [23:0]       v_ext, scaled;
   logic signed [ACC_W:0]    add_sum;
   logic signed [ACC_W-1:0]  acc_sel, sat_acc;
   logic [BTN_IDX_W-1:0]     btn_idx;

   logic                     div_start, div_done;
   logic [ACC_W-1:0]         div_dividend, quo_mag;
   logic [SENS_W-1:0]        div_divisor, rem_mag, sens_sel;

   logic [LIMIT_W-1:0]       limit_sel;
   logic [LW-1:0]            limit_ext, cmax_ext, lim_eff;
   logic [COORD_BITS-1:0]    ptr_sel, ptr_new;
   logic signed [ACC_W:0]    q_signed;
   logic signed [ACC_W-1:0]  rem_signed;
   logic signed [PSW-1:0]    p_sum, p_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RST;
         y_limit_ff <= Y_LIMIT_RST;
         x_sens_ff  <= X_SENS_RST;
         y_sens_ff  <= Y_SENS_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_X_LIMIT: x_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_Y_LIMIT: y_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_X_SENS:  x_sens_ff  <= csr_data[SENS_W-1:0];
            CSR_Y_SENS:  y_sens_ff  <= csr_data[SENS_W-1:0];
            default: ;
         endcase
      end
   end

   // Delta times one hundred, then a saturating add into the chosen accumulator.
   always_comb begin
      v_ext   = 24'(event_value);
      scaled  = (v_ext <<< 6) + (v_ext <<< 5) + (v_ext <<< 2);
      acc_sel = (event_kind == KIND_Y_DELTA) ? y_acc_ff : x_acc_ff;
      add_sum = (ACC_W+1)'(acc_sel) + (ACC_W+1)'(scaled);
      if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
         sat_acc = add_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_acc = add_sum[ACC_W-1:0];
      end
      btn_idx = BTN_IDX_W'(event_kind - KIND_BTN0);
   end

   // Divider operands: the x axis at the start of a batch, the y axis after it.
   always_comb begin
      div_start    = cmd.start_x | cmd.next_y;
      sens_sel     = cmd.next_y ? y_sens_ff : x_sens_ff;
      div_divisor  = (sens_sel == '0) ? SENS_W'(1) : sens_sel;
      div_dividend = cmd.next_y ? ((y_acc_ff[ACC_W-1]) ? -y_acc_ff : y_acc_ff)
                                : ((x_acc_ff[ACC_W-1]) ? -x_acc_ff : x_acc_ff);
      neg_in       = div_start ? (cmd.next_y ? y_acc_ff[ACC_W-1] : x_acc_ff[ACC_W-1])
                               : neg_ff;
   end

   mpt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (quo_mag),
      .remainder (rem_mag)
   );

   // Signed quotient moves the pointer, clamped to zero and the effective limit.
   always_comb begin
      limit_sel  = cmd.finish_y ? y_limit_ff : x_limit_ff;
      ptr_sel    = cmd.finish_y ? ptr_y_ff : ptr_x_ff;
      limit_ext  = LW'(limit_sel);
      cmax_ext   = LW'({COORD_BITS{1'b1}});
      lim_eff    = (limit_ext > cmax_ext) ? cmax_ext : limit_ext;
      q_signed   = neg_ff ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
      rem_signed = neg_ff ? -$signed(ACC_W'(rem_mag)) : $signed(ACC_W'(rem_mag));
      p_sum      = $signed(PSW'(ptr_sel)) + PSW'(q_signed);
      p_lim      = $signed(PSW'(lim_eff));
      if (p_sum > p_lim) begin
         ptr_new = COORD_BITS'(lim_eff);
      end else if (p_sum < 0) begin
         ptr_new = '0;
      end else begin
         ptr_new = p_sum[COORD_BITS-1:0];
      end
   end

   always_comb begin
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      ptr_x_in = ptr_x_ff;
      ptr_y_in = ptr_y_ff;
      wheel_in = wheel_ff;
      btn_in   = btn_ff;
      if (cmd.apply_event) begin
         if (event_kind == KIND_X_DELTA) begin
            x_acc_in = sat_acc;
         end else if (event_kind == KIND_Y_DELTA) begin
            y_acc_in = sat_acc;
         end else if (event_kind == KIND_WHEEL) begin
            if (event_value > 0) begin
               wheel_in = wheel_ff + 1'b1;
            end else if (event_value < 0) begin
               wheel_in = wheel_ff - 1'b1;
            end
         end else if (event_kind <= KIND_BTN7) begin
            btn_in[btn_idx] = event_value[PRESS_BIT];
         end
      end
      if (cmd.next_y) begin
         x_acc_in = rem_signed;
         ptr_x_in = ptr_new;
      end
      if (cmd.finish_y) begin
         y_acc_in = rem_signed;
         ptr_y_in = ptr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         ptr_x_ff <= '0;
         ptr_y_ff <= '0;
         wheel_ff <= '0;
         btn_ff   <= '0;
      end else begin
         x_acc_ff <= x_acc_in;
         y_acc_ff <= y_acc_in;
         ptr_x_ff <= ptr_x_in;
         ptr_y_ff <= ptr_y_in;
         wheel_ff <= wheel_in;
         btn_ff   <= btn_in;
      end
      neg_ff <= neg_in;
   end

   assign stat.div_done = div_done;
   assign pointer_x     = ptr_x_ff;
   assign pointer_y     = ptr_y_ff;
   assign wheel_count   = $signed(wheel_ff);
   assign button_bits   = btn_ff;

endmodule

@@ sv/mpt_ctrl.sv @@
module mpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   command,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output mpt_pkg::mpt_cmd_type   cmd,
   input  mpt_pkg::mpt_stat_type  stat
);
   import mpt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIVX = 4'b0010,
      ST_DIVY = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      accept       = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               if (command == CMD_BATCH) begin
                  cmd.start_x = 1'b1;
                  state_in    = ST_DIVX;
               end else begin
                  cmd.apply_event = 1'b1;
                  state_in        = ST_RESP;
               end
            end
         end
         ST_DIVX: begin
            if (stat.div_done) begin
               cmd.next_y = 1'b1;
               state_in   = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (stat.div_done) begin
               cmd.finish_y = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/mouse_pointer_tracker.sv @@
// An event item gives its result in the cycle after it is accepted; an end-of-batch
// item runs two 32-step divisions, one after the other, on one shared divider.
// One item at a time: the next item is taken in the cycle after the result is taken,
// so the block takes no new item before it is through with the last one.
// Reset is synchronous and active high: pointer, wheel, buttons and accumulators
// clear to zero and the registers return to limits 319 and 199 and sensitivities 135.
module mouse_pointer_tracker #(
   parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // event_value
   input  logic [mpt_pkg::VALUE_W-1:0]            req_tdata,
   // command, event_kind
   input  logic [mpt_pkg::REQ_USER_W-1:0]         req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pointer_x, pointer_y, wheel_count, button_bits, zero padding
   output logic [((2*COORD_BITS+mpt_pkg::WHEEL_W+mpt_pkg::BTN_W+7)/8)*8-1:0] rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mpt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mpt_pkg::CSR_DATA_W-1:0]         csr_data
);
   import mpt_pkg::*;

   localparam int RSP_W = ((2*COORD_BITS + WHEEL_W + BTN_W + 7) / 8) * 8;

   mpt_cmd_type           cmd;
   mpt_stat_type          stat;
   logic [COORD_BITS-1:0] pointer_x, pointer_y;
   logic signed [WHEEL_W-1:0] wheel_count;
   logic [BTN_W-1:0]      button_bits;

   assign csr_ready = 1'b1;

   mpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mpt_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .event_kind  (req_tuser[KIND_W:1]),
      .event_value ($signed(req_tdata)),
      .csr_write   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pointer_x   (pointer_x),
      .pointer_y   (pointer_y),
      .wheel_count (wheel_count),
      .button_bits (button_bits)
   );

   assign rsp_tdata = RSP_W'({button_bits, wheel_count, pointer_y, pointer_x});

endmodule

@@ sv/mpt_checker.sv @@
module mpt_checker #(
   parameter int COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tvalid,
   input logic                                   req_tready,
   input logic [mpt_pkg::REQ_USER_W-1:0]         req_tuser,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [((2*COORD_BITS+mpt_pkg::WHEEL_W+mpt_pkg::BTN_W+7)/8)*8-1:0] rsp_tdata
);
   import mpt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("new item offered while a result is pending");

   a_event_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == CMD_EVENT) |=> rsp_tvalid)
      else $error("event item result not presented after one cycle");

   a_batch_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == CMD_BATCH) |=> !rsp_tvalid && !req_tready)
      else $error("end-of-batch item finished too early");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result item repeated");

endmodule

bind mouse_pointer_tracker mpt_checker #(.COORD_BITS(COORD_BITS)) u_mpt_checker (.*);
